/* src/ctsd_pkg.sv */
`default_nettype none

package ctsd_pkg;

	localparam int BYTE_W             = 8;
	localparam int TABLE_DEPTH        = 256;
	localparam int TABLE_AW           = $clog2(TABLE_DEPTH);
	localparam int KEPT_COUNT_W       = 16;
	localparam int COUNT_BITS_DEFAULT = 16;
	localparam int CFG_INDEX_W        = 1;
	localparam int CFG_DATA_W         = 1;

	typedef enum logic {
		OP_DATA     = 1'b0,
		OP_TABLE_WR = 1'b1
	} op_e;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_REPLACE_MODE = 1'b0,
		REG_SQUEEZE_EN   = 1'b1
	} cfg_reg_e;

	// One table entry: set membership and translation target
	typedef struct packed {
		logic              in_set;
		logic [BYTE_W-1:0] target;
	} entry_t;

	// Item fields that travel with the table lookup
	typedef struct packed {
		op_e               op;
		logic [BYTE_W-1:0] byte_val;
		logic              sos;
		logic              eos;
	} item_t;

	// Configuration write beat
	typedef struct packed {
		logic                   we;
		cfg_reg_e               index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_wr_t;

endpackage

`default_nettype wire

/* src/ctsd_table.sv */
`default_nettype none

module ctsd_table (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             rd_en,
	input  wire                             wr_en,
	input  wire  [ctsd_pkg::TABLE_AW-1:0]   addr,
	input  ctsd_pkg::entry_t                wr_entry,
	output ctsd_pkg::entry_t                rd_entry
);
	import ctsd_pkg::*;

	entry_t                  mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  written_q;
	entry_t                  rd_s1;
	logic                    hit_s1;
	logic [TABLE_AW-1:0]     addr_s1;

	// Synchronous single-port memory, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_s1   <= mem[addr];
			addr_s1 <= addr;
		end
	end

	// Entries never written read as identity, not in set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_s1    <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_s1 <= written_q[addr];
			end
		end
	end

	always_comb begin
		if (hit_s1) begin
			rd_entry = rd_s1;
		end else begin
			rd_entry.in_set = 1'b0;
			rd_entry.target = BYTE_W'(addr_s1);
		end
	end

endmodule

`default_nettype wire

/* src/ctsd_filter.sv */
`default_nettype none

module ctsd_filter #(
	parameter int COUNT_BITS = ctsd_pkg::COUNT_BITS_DEFAULT
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  ctsd_pkg::cfg_wr_t                   cfg,
	input  wire                                 step,
	input  ctsd_pkg::item_t                     item,
	input  ctsd_pkg::entry_t                    entry,
	input  wire                                 out_ready,
	output logic                                out_valid,
	output logic [ctsd_pkg::BYTE_W-1:0]         out_byte,
	output logic                                keep,
	output logic                                string_done,
	output logic [ctsd_pkg::KEPT_COUNT_W-1:0]   kept_count
);
	import ctsd_pkg::*;

	logic                   replace_q;
	logic                   squeeze_q;
	logic [BYTE_W-1:0]      prev_byte_q;
	logic                   prev_vld_q;
	logic [COUNT_BITS-1:0]  cnt_q;

	logic                   is_data;
	logic [BYTE_W-1:0]      prev_byte_eff;
	logic                   prev_vld_eff;
	logic [COUNT_BITS-1:0]  cnt_eff;
	logic                   squeezed;
	logic                   keep_nxt;
	logic [BYTE_W-1:0]      byte_nxt;
	logic [COUNT_BITS-1:0]  cnt_nxt;

	always_comb begin
		is_data       = (item.op == OP_DATA);
		prev_byte_eff = item.sos ? '0 : prev_byte_q;
		prev_vld_eff  = item.sos ? 1'b0 : prev_vld_q;
		cnt_eff       = item.sos ? '0 : cnt_q;
		squeezed      = squeeze_q && entry.in_set && prev_vld_eff
			&& (prev_byte_eff == item.byte_val);
		keep_nxt      = is_data && !squeezed && (replace_q || !entry.in_set);
		byte_nxt      = replace_q ? entry.target : item.byte_val;
		cnt_nxt       = cnt_eff + COUNT_BITS'(keep_nxt);
	end

	// Mode registers and per-string history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_q   <= 1'b1;
			squeeze_q   <= 1'b0;
			prev_byte_q <= '0;
			prev_vld_q  <= 1'b0;
			cnt_q       <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg.we) begin
				unique case (cfg.index)
					REG_REPLACE_MODE: replace_q <= cfg.data[0];
					REG_SQUEEZE_EN:   squeeze_q <= cfg.data[0];
					default:          ;
				endcase
			end
			if (step && is_data) begin
				cnt_q <= cnt_nxt;
				if (!squeezed) begin
					prev_byte_q <= item.byte_val;
					prev_vld_q  <= 1'b1;
				end
			end
			if (step) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte    <= keep_nxt ? byte_nxt : '0;
			keep        <= keep_nxt;
			string_done <= is_data && item.eos;
			kept_count  <= KEPT_COUNT_W'(is_data ? cnt_nxt : cnt_q);
		end
	end

endmodule

`default_nettype wire

/* src/char_translate_squeeze_delete.sv */
// Channel   Dir  Handshake            Beat contents
// in        in   in_valid/in_ready    operation, byte_value, start_of_string,
//                                     end_of_string, entry_in_set, entry_target
// out       out  out_valid/out_ready  out_byte, keep, string_done, kept_count
// cfg       in   cfg_we               cfg_index, cfg_data (no wait, no read-back)
//
// One beat per cycle sustained while out_ready stays high; each beat passes from input to output
// through the table read register (loaded at accept), then the filter and output register.
// The single table memory port serves every beat: one read, plus a write for a table write.
// Reset sets every table entry to identity and not in set through per-entry
// written bits, so the block takes beats right after reset.
// An output stall holds the lookup stage; in_ready drops only when both are full.
`default_nettype none

module char_translate_squeeze_delete #(
	parameter int COUNT_BITS = ctsd_pkg::COUNT_BITS_DEFAULT
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration
	input  wire                                   cfg_we,
	input  wire  [ctsd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire  [ctsd_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input channel
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   operation,
	input  wire  [ctsd_pkg::BYTE_W-1:0]           byte_value,
	input  wire                                   start_of_string,
	input  wire                                   end_of_string,
	input  wire                                   entry_in_set,
	input  wire  [ctsd_pkg::BYTE_W-1:0]           entry_target,
	// output channel
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [ctsd_pkg::BYTE_W-1:0]           out_byte,
	output logic                                  keep,
	output logic                                  string_done,
	output logic [ctsd_pkg::KEPT_COUNT_W-1:0]     kept_count
);
	import ctsd_pkg::*;

	logic     accept;
	logic     advance;
	logic     step;
	logic     valid_s1;
	item_t    item_s1;
	item_t    item_in;
	entry_t   wr_entry;
	entry_t   rd_entry;
	cfg_wr_t  cfg;

	// Pack the input beat
	always_comb begin
		item_in.op       = op_e'(operation);
		item_in.byte_val = byte_value;
		item_in.sos      = start_of_string;
		item_in.eos      = end_of_string;
		wr_entry.in_set  = entry_in_set;
		wr_entry.target  = entry_target;
		cfg.we           = cfg_we;
		cfg.index        = cfg_reg_e'(cfg_index);
		cfg.data         = cfg_data;
	end

	// The output register frees up when empty or being drained; the lookup
	// stage advances into it then, and a new beat may enter behind it.
	assign advance  = !out_valid || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// Table writes land at accept, so the next beat's read already sees them:
	// the port takes one address per cycle and no bypass is needed.
	ctsd_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.wr_en    (accept && (item_in.op == OP_TABLE_WR)),
		.addr     (byte_value),
		.wr_entry (wr_entry),
		.rd_entry (rd_entry)
	);

	// Lookup stage: hold the beat fields alongside the registered table data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	// Squeeze, translate or delete, count, and drive the output register
	ctsd_filter #(
		.COUNT_BITS (COUNT_BITS)
	) u_filter (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (step),
		.item        (item_s1),
		.entry       (rd_entry),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.keep        (keep),
		.string_done (string_done),
		.kept_count  (kept_count)
	);

`ifndef SYNTHESIS
	// An accepted beat always occupies the lookup stage next cycle
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat did not reach lookup stage");

	// Backpressure only comes from a full lookup stage behind a stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("in_ready low without a stall");

	// A stalled lookup stage keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("lookup stage lost its beat during a stall");

	// A table write never emits a kept byte
	a_write_no_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (item_s1.op == OP_TABLE_WR)) |=> (!keep && !string_done))
		else $error("table write produced a kept byte");
`endif

endmodule

`default_nettype wire

/* dv/tb_char_translate_squeeze_delete.sv */
`default_nettype none

module tb_char_translate_squeeze_delete;

	import ctsd_pkg::*;

	localparam int COUNT_W     = COUNT_BITS_DEFAULT;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_BEATS = 125;

	localparam logic Y = 1'b1;
	localparam logic N = 1'b0;
	localparam cfg_reg_e RPL = REG_REPLACE_MODE;
	localparam cfg_reg_e SQZ = REG_SQUEEZE_EN;

	// one input beat, field for field
	typedef struct packed {
		op_e               op;
		logic [BYTE_W-1:0] byte_val;
		logic              sos;
		logic              eos;
		logic              in_set;
		logic [BYTE_W-1:0] target;
	} beat_t;

	// one output beat, field for field
	typedef struct packed {
		logic [BYTE_W-1:0]       out_byte;
		logic                    keep;
		logic                    string_done;
		logic [KEPT_COUNT_W-1:0] kept_count;
	} result_t;

	typedef enum logic {
		ROW_BEAT = 1'b0,
		ROW_REG  = 1'b1
	} row_kind_e;

	// directed row: either a register write (sel, val) or a beat, with the
	// expected result typed in where "typed" is set
	typedef struct packed {
		row_kind_e kind;
		cfg_reg_e  sel;
		logic      val;
		beat_t     beat;
		logic      typed;
		result_t   res;
	} dir_row_t;

	localparam int DIRECTED_ROWS = 26;
	localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
		// identity table after reset, replace mode, squeeze off
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h00, Y, N, N, 8'h00}, Y, '{8'h00, Y, N, 16'd1}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'hFF, N, Y, Y, 8'hFF}, Y, '{8'hFF, Y, Y, 16'd2}},
		// table writes ignore framing bits and leave the count alone
		'{ROW_BEAT, RPL, N, '{OP_TABLE_WR, 8'h41, Y, Y, Y, 8'h61}, Y, '{8'h00, N, N, 16'd2}},
		'{ROW_BEAT, RPL, N, '{OP_TABLE_WR, 8'hFF, N, N, Y, 8'h00}, Y, '{8'h00, N, N, 16'd2}},
		'{ROW_BEAT, RPL, N, '{OP_TABLE_WR, 8'h00, N, N, Y, 8'hFF}, Y, '{8'h00, N, N, 16'd2}},
		// string carries on past end of string: count keeps running
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h41, N, N, N, 8'h00}, Y, '{8'h61, Y, N, 16'd3}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'hFF, N, N, N, 8'h00}, Y, '{8'h00, Y, N, 16'd4}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h00, N, N, N, 8'h00}, Y, '{8'hFF, Y, N, 16'd5}},
		// entry outside the set still translates in replace mode
		'{ROW_BEAT, RPL, N, '{OP_TABLE_WR, 8'h42, N, N, N, 8'h7A}, Y, '{8'h00, N, N, 16'd5}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h42, N, Y, N, 8'h00}, Y, '{8'h7A, Y, Y, 16'd6}},
		// squeeze on: repeated set byte drops, repeated non-set byte stays
		'{ROW_REG,  SQZ, Y, '{OP_DATA, 8'h00, N, N, N, 8'h00}, N, '{8'h00, N, N, 16'd0}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h41, Y, N, N, 8'h00}, Y, '{8'h61, Y, N, 16'd1}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h41, N, N, N, 8'h00}, Y, '{8'h00, N, N, 16'd1}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h41, N, Y, N, 8'h00}, Y, '{8'h00, N, Y, 16'd1}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h42, N, N, N, 8'h00}, N, '{8'h00, N, N, 16'd0}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h42, N, N, N, 8'h00}, N, '{8'h00, N, N, 16'd0}},
		// delete mode; first byte after start of string is never squeezed
		'{ROW_REG,  RPL, N, '{OP_DATA, 8'h00, N, N, N, 8'h00}, N, '{8'h00, N, N, 16'd0}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h00, Y, N, N, 8'h00}, Y, '{8'h00, N, N, 16'd0}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h00, N, N, N, 8'h00}, N, '{8'h00, N, N, 16'd0}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h43, N, N, N, 8'h00}, N, '{8'h00, N, N, 16'd0}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'hFF, N, N, N, 8'h00}, N, '{8'h00, N, N, 16'd0}},
		// squeeze off: history still tracks every byte
		'{ROW_REG,  SQZ, N, '{OP_DATA, 8'h00, N, N, N, 8'h00}, N, '{8'h00, N, N, 16'd0}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'hFF, N, N, N, 8'h00}, N, '{8'h00, N, N, 16'd0}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h43, N, Y, N, 8'h00}, N, '{8'h00, N, N, 16'd0}},
		'{ROW_REG,  RPL, Y, '{OP_DATA, 8'h00, N, N, N, 8'h00}, N, '{8'h00, N, N, 16'd0}},
		'{ROW_BEAT, RPL, N, '{OP_DATA, 8'h43, Y, Y, N, 8'h00}, N, '{8'h00, N, N, 16'd0}}
	};

	// clock, reset and block inputs, all known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic operation = 1'b0;
	logic [BYTE_W-1:0] byte_value = '0;
	logic start_of_string = 1'b0;
	logic end_of_string = 1'b0;
	logic entry_in_set = 1'b0;
	logic [BYTE_W-1:0] entry_target = '0;
	logic out_ready = 1'b0;

	logic in_ready;
	logic out_valid;
	logic [BYTE_W-1:0] out_byte;
	logic keep;
	logic string_done;
	logic [KEPT_COUNT_W-1:0] kept_count;

	// shadow of the block: translation table, squeeze history, kept count, registers
	entry_t xlat_table [TABLE_DEPTH];
	logic [BYTE_W-1:0] prev_byte;
	logic prev_valid;
	logic [COUNT_W-1:0] kept_total;
	logic replace_on;
	logic squeeze_on;

	result_t out_beats_due [$];
	result_t due;
	int mismatches = 0;
	int quiet_cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	logic [BYTE_W-1:0] hot_bytes [4];

	char_translate_squeeze_delete uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.byte_value      (byte_value),
		.start_of_string (start_of_string),
		.end_of_string   (end_of_string),
		.entry_in_set    (entry_in_set),
		.entry_target    (entry_target),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_byte        (out_byte),
		.keep            (keep),
		.string_done     (string_done),
		.kept_count      (kept_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Advance the shadow state by one accepted beat and return the beat it must produce.
	function automatic result_t translate_beat(beat_t b);
		result_t r;
		logic hit;
		logic squeezed;
		r = '0;
		if (b.op == OP_TABLE_WR) begin
			xlat_table[b.byte_val] = '{b.in_set, b.target};
		end else begin
			if (b.sos) begin
				prev_byte = '0;
				prev_valid = 1'b0;
				kept_total = '0;
			end
			hit = xlat_table[b.byte_val].in_set;
			squeezed = squeeze_on && hit && prev_valid && (prev_byte == b.byte_val);
			if (!squeezed) begin
				// history follows the original byte, even if delete mode drops it
				prev_byte = b.byte_val;
				prev_valid = 1'b1;
				if (replace_on) begin
					r.keep = 1'b1;
					r.out_byte = xlat_table[b.byte_val].target;
				end else if (!hit) begin
					r.keep = 1'b1;
					r.out_byte = b.byte_val;
				end
			end
			if (r.keep)
				kept_total = kept_total + 1'b1;
			r.string_done = b.eos;
		end
		r.kept_count = KEPT_COUNT_W'(kept_total);
		return r;
	endfunction

	// Mostly one of a few hot bytes so repeats and set hits are common.
	function automatic logic [BYTE_W-1:0] pick_byte();
		if ($urandom_range(0, 9) < 7)
			return hot_bytes[2'($urandom_range(0, 3))];
		return BYTE_W'($urandom);
	endfunction

	// Offer one beat after a random gap; hold it until accepted, then queue its result.
	task automatic push_beat(beat_t b, logic typed, result_t typed_res);
		result_t r;
		while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= b.op;
		byte_value <= b.byte_val;
		start_of_string <= b.sos;
		end_of_string <= b.eos;
		entry_in_set <= b.in_set;
		entry_target <= b.target;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		r = translate_beat(b);
		out_beats_due.push_back(typed ? typed_res : r);
	endtask

	// Drop valid and wait for the pipeline to empty out.
	task automatic settle();
		in_valid <= 1'b0;
		while (out_beats_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Register writes only land while the block is idle.
	task automatic write_reg(cfg_reg_e sel, logic val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			REG_REPLACE_MODE: replace_on = val;
			REG_SQUEEZE_EN:   squeeze_on = val;
			default:          ;
		endcase
	endtask

	// Receiver: check each accepted beat against the oldest expectation, then
	// pick ready for the next edge.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (out_beats_due.size() == 0) begin
				$error("unexpected output beat: out_byte %0h keep %0b", out_byte, keep);
				mismatches++;
			end else begin
				due = out_beats_due.pop_front();
				if (out_byte !== due.out_byte) begin
					$error("out_byte: expected %0h, got %0h", due.out_byte, out_byte);
					mismatches++;
				end
				if (keep !== due.keep) begin
					$error("keep: expected %0b, got %0b", due.keep, keep);
					mismatches++;
				end
				if (string_done !== due.string_done) begin
					$error("string_done: expected %0b, got %0b", due.string_done,
						string_done);
					mismatches++;
				end
				if (kept_count !== due.kept_count) begin
					$error("kept_count: expected %0d, got %0d", due.kept_count,
						kept_count);
					mismatches++;
				end
			end
		end
		out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog: end the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("char_translate_squeeze_delete: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		beat_t b;
		int left;
		int len;
		logic [BYTE_W-1:0] last_byte;

		// shadow state matches the block's reset values
		for (int i = 0; i < TABLE_DEPTH; i++)
			xlat_table[i] = '{1'b0, BYTE_W'(i)};
		prev_byte = '0;
		prev_valid = 1'b0;
		kept_total = '0;
		replace_on = 1'b1;
		squeeze_on = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, no idling
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_REG)
				write_reg(DIRECTED[i].sel, DIRECTED[i].val);
			else
				push_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].res);
		end

		// random phases: every register setting and every idling pattern, each used twice
		for (int p = 0; p < 8; p++) begin
			write_reg(REG_REPLACE_MODE, 1'(p[2] ^ p[0]));
			write_reg(REG_SQUEEZE_EN, 1'(p[2] ^ p[1]));
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 51; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 51; end
				default: begin gap_pct = 9; stall_pct = 9; end
			endcase
			for (int h = 0; h < 3; h++)
				hot_bytes[h] = BYTE_W'($urandom);
			hot_bytes[3] = p[0] ? 8'hFF : 8'h00;
			left = PHASE_BEATS;
			last_byte = hot_bytes[0];
			while (left > 0) begin
				if ($urandom_range(0, 9) == 0) begin
					// table write, mostly to hot entries; framing bits are noise here
					b = '{OP_TABLE_WR, pick_byte(), 1'($urandom), 1'($urandom),
						1'($urandom), BYTE_W'($urandom)};
					push_beat(b, 1'b0, '0);
					left--;
				end else begin
					// a framed string with random content and frequent repeats
					len = $urandom_range(1, 12);
					for (int k = 0; k < len && left > 0; k++) begin
						if (k > 0 && $urandom_range(0, 2) == 0)
							b.byte_val = last_byte;
						else
							b.byte_val = pick_byte();
						b.op = OP_DATA;
						b.sos = (k == 0);
						b.eos = (k == len - 1);
						b.in_set = 1'($urandom);
						b.target = BYTE_W'($urandom);
						// now and then break the framing
						if ($urandom_range(0, 9) == 0) begin
							b.sos = 1'($urandom);
							b.eos = 1'($urandom);
						end
						last_byte = b.byte_val;
						push_beat(b, 1'b0, '0);
						left--;
					end
				end
			end
		end

		// drain, then give the pipeline a few more edges to show any stray beat
		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && out_beats_due.size() == 0)
			$display("char_translate_squeeze_delete: match");
		else
			$display("char_translate_squeeze_delete: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
